@@ design/blr_pkg.sv @@
// Shared types and constants of the line rasterizer.
package blr_pkg;

  // Width of the packed line color and of the intensity.
  localparam int COLOR_W = 24;
  localparam int LEVEL_W = 8;

  // Configuration port geometry: four 32-bit registers at byte addresses 0, 4, 8 and 12.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Reset value of the right and bottom clip edges.
  localparam int CLIP_FAR_RESET = 4096;

  // Narrowest clip register that still holds the far reset value.
  localparam int CLIP_MIN_W = 13;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_RIGHT  = 2'd1,
    REG_CLIP_TOP    = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } reg_idx_t;

  // Class of a command that the front hands to the back.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_LINE = 2'd2
  } op_t;

  localparam int OP_W = $bits(op_t);

  // Flags that travel with every pixel.
  typedef struct packed {
    logic inside_clip;
    logic last_pixel;
  } pix_flags_t;

  localparam int FLAGS_W = $bits(pix_flags_t);

endpackage

@@ design/bresenham_line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasterizer with its clip registers and result queue.
//
// Usage. Input beats enter through push/full: a beat is taken at a rising edge with push
// high and full low. An endpoint beat (kind 0) starts a line from the current beam
// position to the target, or only moves the beam when beam_level is zero; it gives no
// result and is dropped while a line is still being drawn. A tick beat (kind 1) on an
// active line gives one pixel, stepping once along the major axis; a tick with no active
// line gives nothing. Results leave through empty/pop: the oldest pixel sits on the
// result ports while empty is low and is taken at an edge with pop high.
// Flow. A front end classifies each beat into a four-entry command queue; the stepper
// behind it executes one command per clock while the result queue has room, so one beat
// per cycle is sustained. A tick's pixel passes the command queue and the result queue
// to reach the ports. The only loop is the stepper's update of beam and error term.
// Stalls. When the receiver stops popping, the two-entry result queue fills, the stepper
// holds, the command queue fills behind it and full rises; nothing is lost.
// Reset. rst is synchronous and active high: both queues empty, the line goes idle with
// the beam at the origin, and the clip window opens to cover 0 to 4095 on both axes.
// The clip registers are written over the APB-style port (pready is always high).
module bresenham_line_rasterizer_unit #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input channel.
  input  logic                                push,
  output logic                                full,
  input  logic                                kind,
  input  logic signed [COORD_BITS-1:0]        target_x,
  input  logic signed [COORD_BITS-1:0]        target_y,
  input  logic [blr_pkg::COLOR_W-1:0]         beam_color,
  input  logic [blr_pkg::LEVEL_W-1:0]         beam_level,
  // Result channel.
  output logic                                empty,
  input  logic                                pop,
  output logic signed [COORD_BITS-1:0]        pixel_x,
  output logic signed [COORD_BITS-1:0]        pixel_y,
  output logic [blr_pkg::COLOR_W-1:0]         pixel_color,
  output logic [blr_pkg::LEVEL_W-1:0]         pixel_level,
  output logic                                inside_clip,
  output logic                                last_pixel,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [blr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [blr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [blr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  // Clip registers are wide enough for both a coordinate and the far reset value.
  localparam int CLIP_W = (COORD_BITS > blr_pkg::CLIP_MIN_W) ? COORD_BITS : blr_pkg::CLIP_MIN_W;
  localparam int CMD_W  = blr_pkg::OP_W + 2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W;
  localparam int OUT_W  = 2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W + blr_pkg::FLAGS_W;
  localparam logic [CLIP_W-1:0] CLIP_FAR = CLIP_W'(blr_pkg::CLIP_FAR_RESET);

  logic [CLIP_W-1:0]     clip_left;
  logic [CLIP_W-1:0]     clip_right;
  logic [CLIP_W-1:0]     clip_top;
  logic [CLIP_W-1:0]     clip_bottom;
  logic                  cfg_write;
  blr_pkg::reg_idx_t     reg_idx;
  logic [CLIP_W-1:0]     wr_value;

  logic [CMD_W-1:0]      cmd_data;
  logic                  cmd_empty;
  logic                  cmd_pop;
  logic                  out_full;
  logic                  out_push;
  logic [OUT_W-1:0]      out_in;
  logic [OUT_W-1:0]      out_head;
  blr_pkg::pix_flags_t   head_flags;

  // Configuration: writes complete in the access phase; written values keep the
  // coordinate width only.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = blr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_value  = CLIP_W'(pwdata[COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_right  <= CLIP_FAR;
      clip_top    <= '0;
      clip_bottom <= CLIP_FAR;
    end else if (cfg_write) begin
      case (reg_idx)
        blr_pkg::REG_CLIP_LEFT:   clip_left   <= wr_value;
        blr_pkg::REG_CLIP_RIGHT:  clip_right  <= wr_value;
        blr_pkg::REG_CLIP_TOP:    clip_top    <= wr_value;
        blr_pkg::REG_CLIP_BOTTOM: clip_bottom <= wr_value;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      blr_pkg::REG_CLIP_LEFT:   prdata = blr_pkg::CFG_DATA_W'(clip_left);
      blr_pkg::REG_CLIP_RIGHT:  prdata = blr_pkg::CFG_DATA_W'(clip_right);
      blr_pkg::REG_CLIP_TOP:    prdata = blr_pkg::CFG_DATA_W'(clip_top);
      blr_pkg::REG_CLIP_BOTTOM: prdata = blr_pkg::CFG_DATA_W'(clip_bottom);
      default:                  prdata = '0;
    endcase
  end

  // Front end: classification and command queue.
  blr_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_DEPTH  (4)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .target_x   (target_x),
    .target_y   (target_y),
    .beam_color (beam_color),
    .beam_level (beam_level),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_data)
  );

  // Back end: the stepper owns all line state.
  blr_back #(
    .COORD_BITS (COORD_BITS),
    .CLIP_W     (CLIP_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_data    (cmd_data),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .clip_left   (clip_left),
    .clip_right  (clip_right),
    .clip_top    (clip_top),
    .clip_bottom (clip_bottom),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_data    (out_in)
  );

  // Result queue: lets the stepper keep going while a finished pixel waits.
  blr_queue #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .full      (out_full),
    .push_data (out_in),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (out_head)
  );

  assign pixel_x     = out_head[OUT_W-1 -: COORD_BITS];
  assign pixel_y     = out_head[OUT_W-COORD_BITS-1 -: COORD_BITS];
  assign pixel_color = out_head[blr_pkg::FLAGS_W + blr_pkg::LEVEL_W +: blr_pkg::COLOR_W];
  assign pixel_level = out_head[blr_pkg::FLAGS_W +: blr_pkg::LEVEL_W];
  assign head_flags  = blr_pkg::pix_flags_t'(out_head[blr_pkg::FLAGS_W-1:0]);
  assign inside_clip = head_flags.inside_clip;
  assign last_pixel  = head_flags.last_pixel;

endmodule

@@ design/blr_queue.sv @@
// Small register-based first-in first-out queue with push/full and pop/empty sides.
module blr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  // Users keep DEPTH a power of two so pointers wrap; the queue does not check it.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/blr_front.sv @@
// Front end: accepts input beats, classifies them and queues commands for the stepper.
module blr_front #(
  parameter int COORD_BITS = 13,
  parameter int CMD_DEPTH  = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic signed [COORD_BITS-1:0]   target_x,
  input  logic signed [COORD_BITS-1:0]   target_y,
  input  logic [blr_pkg::COLOR_W-1:0]    beam_color,
  input  logic [blr_pkg::LEVEL_W-1:0]    beam_level,
  input  logic                           cmd_pop,
  output logic                           cmd_empty,
  output logic [blr_pkg::OP_W + 2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W - 1:0]
                                         cmd_data
);

  localparam int CMD_W = blr_pkg::OP_W + 2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W;

  blr_pkg::op_t     op;
  logic [CMD_W-1:0] cmd_in;

  // A zero intensity turns an endpoint into a plain beam move.
  always_comb begin
    if (kind) begin
      op = blr_pkg::OP_TICK;
    end else if (beam_level == '0) begin
      op = blr_pkg::OP_MOVE;
    end else begin
      op = blr_pkg::OP_LINE;
    end
  end

  assign cmd_in = {op, target_x, target_y, beam_color, beam_level};

  blr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .empty     (cmd_empty),
    .pop_data  (cmd_data)
  );

endmodule

@@ design/blr_back.sv @@
// Back end: Bresenham stepper that executes queued commands and emits pixels.
module blr_back #(
  parameter int COORD_BITS = 13,
  parameter int CLIP_W     = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [blr_pkg::OP_W + 2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W - 1:0]
                              cmd_data,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic [CLIP_W-1:0]   clip_left,
  input  logic [CLIP_W-1:0]   clip_right,
  input  logic [CLIP_W-1:0]   clip_top,
  input  logic [CLIP_W-1:0]   clip_bottom,
  input  logic                out_full,
  output logic                out_push,
  output logic [2*COORD_BITS + blr_pkg::COLOR_W + blr_pkg::LEVEL_W + blr_pkg::FLAGS_W - 1:0]
                              out_data
);

  localparam int C     = COORD_BITS;
  localparam int D_W   = C + 1;
  localparam int E_W   = C + 2;
  localparam int CMD_W = blr_pkg::OP_W + 2*C + blr_pkg::COLOR_W + blr_pkg::LEVEL_W;

  // Command fields.
  blr_pkg::op_t                 cmd_op;
  logic signed [C-1:0]          cmd_tx;
  logic signed [C-1:0]          cmd_ty;
  logic [blr_pkg::COLOR_W-1:0]  cmd_color;
  logic [blr_pkg::LEVEL_W-1:0]  cmd_level;

  // Line state.
  logic signed [C-1:0]          beam_x;
  logic signed [C-1:0]          beam_y;
  logic signed [C-1:0]          end_x;
  logic signed [C-1:0]          end_y;
  logic [D_W-1:0]               delta_major;
  logic [D_W-1:0]               delta_minor;
  logic signed [E_W-1:0]        error_term;
  logic                         x_is_major;
  logic                         step_x_negative;
  logic                         step_y_negative;
  logic                         line_active;
  logic [blr_pkg::COLOR_W-1:0]  line_color;
  logic [blr_pkg::LEVEL_W-1:0]  line_level;

  // Setup arithmetic.
  logic signed [D_W-1:0]        diff_x;
  logic signed [D_W-1:0]        diff_y;
  logic [D_W-1:0]               abs_x;
  logic [D_W-1:0]               abs_y;
  logic                         set_x_major;

  // Step arithmetic.
  logic                         go;
  logic                         is_last;
  logic                         in_window;
  logic signed [E_W-1:0]        err_sub;
  logic                         minor_step;
  logic signed [E_W-1:0]        err_next;
  logic signed [C-1:0]          step_x;
  logic signed [C-1:0]          step_y;
  logic [CLIP_W-1:0]            ux;
  logic [CLIP_W-1:0]            uy;
  blr_pkg::pix_flags_t          flags;

  assign cmd_op    = blr_pkg::op_t'(cmd_data[CMD_W-1 -: blr_pkg::OP_W]);
  assign cmd_tx    = cmd_data[CMD_W-blr_pkg::OP_W-1 -: C];
  assign cmd_ty    = cmd_data[CMD_W-blr_pkg::OP_W-C-1 -: C];
  assign cmd_color = cmd_data[blr_pkg::LEVEL_W +: blr_pkg::COLOR_W];
  assign cmd_level = cmd_data[blr_pkg::LEVEL_W-1:0];

  // The stepper takes one command per cycle whenever a result has room to go.
  assign go       = !cmd_empty && !out_full;
  assign cmd_pop  = go;
  assign out_push = go && (cmd_op == blr_pkg::OP_TICK) && line_active;

  // Deltas from the new endpoint to the current beam, one bit wider than a coordinate.
  assign diff_x      = D_W'(beam_x) - D_W'(cmd_tx);
  assign diff_y      = D_W'(beam_y) - D_W'(cmd_ty);
  assign abs_x       = diff_x[D_W-1] ? D_W'(-diff_x) : D_W'(diff_x);
  assign abs_y       = diff_y[D_W-1] ? D_W'(-diff_y) : D_W'(diff_y);
  assign set_x_major = (abs_x >= abs_y);

  assign is_last = x_is_major ? (beam_x == end_x) : (beam_y == end_y);

  // Negative coordinates always lie outside the window.
  assign ux        = CLIP_W'($unsigned(beam_x));
  assign uy        = CLIP_W'($unsigned(beam_y));
  assign in_window = !beam_x[C-1] && !beam_y[C-1] &&
                     (ux >= clip_left) && (ux < clip_right) &&
                     (uy >= clip_top) && (uy < clip_bottom);

  assign err_sub    = error_term - E_W'(delta_minor);
  assign minor_step = err_sub[E_W-1];
  assign err_next   = minor_step ? (err_sub + E_W'(delta_major)) : err_sub;
  assign step_x     = step_x_negative ? (beam_x - C'(1)) : (beam_x + C'(1));
  assign step_y     = step_y_negative ? (beam_y - C'(1)) : (beam_y + C'(1));

  assign flags.inside_clip = in_window;
  assign flags.last_pixel  = is_last;
  assign out_data = {beam_x, beam_y, line_color, line_level, flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_x          <= '0;
      beam_y          <= '0;
      end_x           <= '0;
      end_y           <= '0;
      delta_major     <= '0;
      delta_minor     <= '0;
      error_term      <= '0;
      x_is_major      <= 1'b0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      line_active     <= 1'b0;
      line_color      <= '0;
      line_level      <= '0;
    end else if (go) begin
      case (cmd_op)
        blr_pkg::OP_MOVE: begin
          if (!line_active) begin
            beam_x <= cmd_tx;
            beam_y <= cmd_ty;
          end
        end
        blr_pkg::OP_LINE: begin
          if (!line_active) begin
            end_x           <= cmd_tx;
            end_y           <= cmd_ty;
            step_x_negative <= !diff_x[D_W-1] && (diff_x != '0);
            step_y_negative <= !diff_y[D_W-1] && (diff_y != '0);
            x_is_major      <= set_x_major;
            delta_major     <= set_x_major ? abs_x : abs_y;
            delta_minor     <= set_x_major ? abs_y : abs_x;
            error_term      <= E_W'(set_x_major ? (abs_x >> 1) : (abs_y >> 1));
            line_color      <= cmd_color;
            line_level      <= cmd_level;
            line_active     <= 1'b1;
          end
        end
        blr_pkg::OP_TICK: begin
          if (line_active) begin
            if (is_last) begin
              beam_x      <= end_x;
              beam_y      <= end_y;
              line_active <= 1'b0;
            end else begin
              error_term <= err_next;
              if (x_is_major) begin
                beam_x <= step_x;
                if (minor_step) begin
                  beam_y <= step_y;
                end
              end else begin
                beam_y <= step_y;
                if (minor_step) begin
                  beam_x <= step_x;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ bench/blr_tb_pkg.sv @@
// Beat kind codes shared by the testbench top and the pixel checker.
package blr_tb_pkg;

  typedef enum logic {
    BEAT_ENDPOINT = 1'b0,
    BEAT_TICK     = 1'b1
  } beat_kind_t;

endpackage

@@ bench/blr_pixel_checker.sv @@
// Pixel checker: follows the rasterizer's channels, predicts each pixel and compares it.
module blr_pixel_checker
  import blr_pkg::*;
  import blr_tb_pkg::*;
#(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic                          kind,
  input  logic signed [COORD_BITS-1:0]  target_x,
  input  logic signed [COORD_BITS-1:0]  target_y,
  input  logic [COLOR_W-1:0]            beam_color,
  input  logic [LEVEL_W-1:0]            beam_level,
  input  logic                          empty,
  input  logic                          pop,
  input  logic signed [COORD_BITS-1:0]  pixel_x,
  input  logic signed [COORD_BITS-1:0]  pixel_y,
  input  logic [COLOR_W-1:0]            pixel_color,
  input  logic [LEVEL_W-1:0]            pixel_level,
  input  logic                          inside_clip,
  input  logic                          last_pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  input  logic                          pready,
  output int                            failures,
  output int                            pending,
  output int                            pixels_checked
);

  typedef struct {
    int x;
    int y;
    int color;
    int level;
    bit in_clip;
    bit at_end;
  } pixel_t;

  pixel_t pixels_due[$];
  pixel_t want_px;
  pixel_t fresh_px;

  int win_left, win_right, win_top, win_bottom;
  int pos_x, pos_y, stop_x, stop_y;
  int major_span, minor_span, slope_err;
  bit major_is_x, x_goes_down, y_goes_down, drawing;
  int ink_color, ink_level;

  task automatic clear_state();
    win_left = 0;
    win_right = CLIP_FAR_RESET;
    win_top = 0;
    win_bottom = CLIP_FAR_RESET;
    pos_x = 0;
    pos_y = 0;
    stop_x = 0;
    stop_y = 0;
    major_span = 0;
    minor_span = 0;
    slope_err = 0;
    major_is_x = 1'b0;
    x_goes_down = 1'b0;
    y_goes_down = 1'b0;
    drawing = 1'b0;
    ink_color = 0;
    ink_level = 0;
  endtask

  // Advances the line state by one accepted beat; returns 1 when the beat yields a pixel.
  function automatic bit rasterize(input logic k, input int tx, input int ty,
                                   input int color, input int level, output pixel_t px);
    int dx, dy, sx, sy;
    px = '{default: 0};
    if (k == BEAT_ENDPOINT) begin
      if (drawing) return 1'b0;
      if (level == 0) begin
        pos_x = tx;
        pos_y = ty;
        return 1'b0;
      end
      stop_x = tx;
      stop_y = ty;
      dx = (pos_x > tx) ? pos_x - tx : tx - pos_x;
      dy = (pos_y > ty) ? pos_y - ty : ty - pos_y;
      x_goes_down = pos_x > tx;
      y_goes_down = pos_y > ty;
      major_is_x = dx >= dy;
      major_span = major_is_x ? dx : dy;
      minor_span = major_is_x ? dy : dx;
      slope_err = major_span / 2;
      ink_color = color;
      ink_level = level;
      drawing = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    sx = x_goes_down ? -1 : 1;
    sy = y_goes_down ? -1 : 1;
    px.x = pos_x;
    px.y = pos_y;
    px.color = ink_color;
    px.level = ink_level;
    px.at_end = major_is_x ? (pos_x == stop_x) : (pos_y == stop_y);
    px.in_clip = pos_x >= 0 && pos_y >= 0 && pos_x >= win_left && pos_x < win_right &&
                 pos_y >= win_top && pos_y < win_bottom;
    if (px.at_end) begin
      pos_x = stop_x;
      pos_y = stop_y;
      drawing = 1'b0;
    end else if (major_is_x) begin
      pos_x += sx;
      slope_err -= minor_span;
      if (slope_err < 0) begin
        pos_y += sy;
        slope_err += major_span;
      end
    end else begin
      pos_y += sy;
      slope_err -= minor_span;
      if (slope_err < 0) begin
        pos_x += sx;
        slope_err += major_span;
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      pixels_due.delete();
      failures = 0;
      pixels_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_CLIP_LEFT:   win_left   = int'(pwdata[COORD_BITS-1:0]);
          REG_CLIP_RIGHT:  win_right  = int'(pwdata[COORD_BITS-1:0]);
          REG_CLIP_TOP:    win_top    = int'(pwdata[COORD_BITS-1:0]);
          REG_CLIP_BOTTOM: win_bottom = int'(pwdata[COORD_BITS-1:0]);
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel at x=%0d y=%0d", pixel_x, pixel_y);
          failures++;
        end else begin
          want_px = pixels_due.pop_front();
          check_field("pixel_x", want_px.x, int'(pixel_x));
          check_field("pixel_y", want_px.y, int'(pixel_y));
          check_field("pixel_color", want_px.color, int'(pixel_color));
          check_field("pixel_level", want_px.level, int'(pixel_level));
          check_field("inside_clip", int'(want_px.in_clip), int'(inside_clip));
          check_field("last_pixel", int'(want_px.at_end), int'(last_pixel));
          pixels_checked++;
        end
      end
      if (push && !full) begin
        if (rasterize(kind, int'(target_x), int'(target_y), int'(beam_color),
                      int'(beam_level), fresh_px))
          pixels_due.push_back(fresh_px);
      end
    end
    pending = pixels_due.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top: drives beats and clip writes into the line rasterizer and gives the verdict.
module tb_top;
  import blr_pkg::*;
  import blr_tb_pkg::*;

  localparam int COORD_BITS = 13;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  // Effective beats per random phase; five phases give about 400 in all.
  localparam int BEATS_PER_PHASE = 80;
  localparam int PHASES = 5;
  // The command queue holds four beats and the pixel path is two stages deep, so
  // SETTLE_CYCLES is ample for trailing endpoint beats to retire after the last pixel.
  localparam int SETTLE_CYCLES = 12;
  // Long enough for the result queue, the stepper and the command queue to back up.
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic kind;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic [COLOR_W-1:0] beam_color;
  logic [LEVEL_W-1:0] beam_level;
  logic empty;
  logic pop;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic [LEVEL_W-1:0] pixel_level;
  logic inside_clip;
  logic last_pixel;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  int failures;
  int pending;
  int pixels_checked;

  // The stimulus side keeps a rough plan of where the beam is and how many pixels the
  // current line still owes. It only steers the stimulus; all checking is in the checker.
  int plan_x;
  int plan_y;
  int pixels_left;
  int beats_sent;
  int beats_counted;
  int lines_started;
  int send_burst;
  int recv_burst;
  int holds_done;
  int cycle_count = 0;
  bit hold_request;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bresenham_line_rasterizer_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind),
    .target_x(target_x), .target_y(target_y),
    .beam_color(beam_color), .beam_level(beam_level),
    .empty(empty), .pop(pop),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_color(pixel_color), .pixel_level(pixel_level),
    .inside_clip(inside_clip), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  blr_pixel_checker #(
    .COORD_BITS(COORD_BITS)
  ) i_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind),
    .target_x(target_x), .target_y(target_y),
    .beam_color(beam_color), .beam_level(beam_level),
    .empty(empty), .pop(pop),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .pixel_color(pixel_color), .pixel_level(pixel_level),
    .inside_clip(inside_clip), .last_pixel(last_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .failures(failures), .pending(pending), .pixels_checked(pixels_checked)
  );

  // Each side draws a random wait before each beat, except during bursts in which it
  // runs flat out; this puts gaps on every phase of the pipeline and also gives stretches
  // of full-rate traffic.
  function automatic int draw_gap(inout int burst);
    int gap;
    gap = 0;
    if (burst > 0) begin
      burst--;
    end else if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
    end else begin
      gap = $urandom_range(0, 7);
    end
    return gap;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic int clamp_clip(input int v);
    return (v < 0) ? 0 : ((v > CLIP_FAR_RESET) ? CLIP_FAR_RESET : v);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_MIN;
  endfunction

  function automatic int near_coord(input int center, input int span);
    return clamp_coord(center + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [COLOR_W-1:0] any_color();
    return COLOR_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // Offers one beat and holds it until the block takes it. Called and returning at a
  // falling edge, so push is never lowered and raised again within one time step.
  task automatic send_beat(input beat_kind_t k, input int tx, input int ty,
                           input logic [COLOR_W-1:0] color, input logic [LEVEL_W-1:0] level);
    int gap;
    gap = draw_gap(send_burst);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    kind <= k;
    target_x <= tx[COORD_BITS-1:0];
    target_y <= ty[COORD_BITS-1:0];
    beam_color <= color;
    beam_level <= level;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    // Beats the block only drops (endpoints during a line, ticks with no line) do not
    // count toward the stimulus total.
    if (k == BEAT_TICK) begin
      if (pixels_left > 0) begin
        pixels_left--;
        beats_counted++;
      end
    end else if (pixels_left == 0) begin
      beats_counted++;
      if (level != 0) begin
        pixels_left = ((plan_x > tx) ? plan_x - tx : tx - plan_x);
        if (((plan_y > ty) ? plan_y - ty : ty - plan_y) > pixels_left)
          pixels_left = (plan_y > ty) ? plan_y - ty : ty - plan_y;
        pixels_left++;
        lines_started++;
      end
      // Either way the beam ends up on the target.
      plan_x = tx;
      plan_y = ty;
    end
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_beat(BEAT_TICK, any_coord(), any_coord(), any_color(),
              LEVEL_W'($urandom_range(0, 255)));
  endtask

  // Stops offering beats until every predicted pixel has come out, then lets the
  // pipeline empty of trailing endpoint beats, which give no pixel to wait for.
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_clip(input reg_idx_t idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(int'(idx) * 4);
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input int left, input int right, input int top, input int bottom);
    write_clip(REG_CLIP_LEFT, left);
    write_clip(REG_CLIP_RIGHT, right);
    write_clip(REG_CLIP_TOP, top);
    write_clip(REG_CLIP_BOTTOM, bottom);
  endtask

  // One random beat, shaped so that most traffic is complete lines: an endpoint followed
  // by the ticks that walk it, with beam moves in between. Noise is mixed in: ticks with
  // no line, and endpoints that arrive mid-line and must be dropped.
  task automatic random_beat();
    int pick;
    int tx;
    int ty;
    int span;
    pick = $urandom_range(0, 99);
    if (pixels_left > 0) begin
      if (pick < 90) begin
        send_tick();
      end else begin
        send_beat(BEAT_ENDPOINT, any_coord(), any_coord(), any_color(),
                  (pick < 95) ? 8'd0 : LEVEL_W'($urandom_range(1, 255)));
      end
    end else if (pick < 8) begin
      send_tick();
    end else if (pick < 25) begin
      // Beam move: mostly a short hop, sometimes a jump anywhere.
      if ($urandom_range(0, 9) < 7) begin
        tx = near_coord(plan_x, 40);
        ty = near_coord(plan_y, 40);
      end else if ($urandom_range(0, 1) == 0) begin
        tx = $urandom_range(0, COORD_MAX);
        ty = $urandom_range(0, COORD_MAX);
      end else begin
        tx = any_coord();
        ty = any_coord();
      end
      send_beat(BEAT_ENDPOINT, tx, ty, any_color(), 8'd0);
    end else begin
      // Lines are mostly a few pixels long; now and then a long one.
      span = ($urandom_range(0, 24) == 0) ? 300 : 6;
      tx = near_coord(plan_x, span);
      ty = near_coord(plan_y, span);
      send_beat(BEAT_ENDPOINT, tx, ty, any_color(), LEVEL_W'($urandom_range(1, 255)));
    end
  endtask

  // Result side: pops with random waits. Once, on request from the stimulus side, it
  // holds off for a long stretch so that the block fills up and raises full.
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(recv_burst);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase_start;
    rst = 1'b1;
    push = 1'b0;
    kind = BEAT_TICK;
    target_x = '0;
    target_y = '0;
    beam_color = '0;
    beam_level = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    plan_x = 0;
    plan_y = 0;
    pixels_left = 0;
    beats_sent = 0;
    beats_counted = 0;
    lines_started = 0;
    send_burst = 0;
    recv_burst = 0;
    holds_done = 0;
    hold_request = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, with the clip window as reset leaves it.
    // A tick with no line yields nothing.
    send_beat(BEAT_TICK, COORD_MAX, COORD_MIN, 24'hFFFFFF, 8'hFF);
    // Zero-intensity endpoints only move the beam, here to both corners of the range.
    send_beat(BEAT_ENDPOINT, COORD_MIN, COORD_MIN, 24'h000000, 8'd0);
    send_beat(BEAT_ENDPOINT, COORD_MAX, COORD_MAX, 24'hFFFFFF, 8'd0);
    // A short x-major line stepping down on both axes from the far corner.
    send_beat(BEAT_ENDPOINT, COORD_MAX - 2, COORD_MAX - 1, 24'hFFFFFF, 8'hFF);
    send_tick();
    // Endpoints that arrive mid-line are dropped, whatever their intensity.
    send_beat(BEAT_ENDPOINT, 0, 0, 24'h00FF00, 8'd0);
    send_beat(BEAT_ENDPOINT, COORD_MIN, COORD_MAX, 24'h0000FF, 8'd7);
    repeat (2) send_tick();
    send_tick();
    // A zero-length line gives one pixel that is also the last.
    send_beat(BEAT_ENDPOINT, COORD_MAX - 2, COORD_MAX - 1, 24'h000000, 8'd1);
    send_tick();
    // A y-major line crossing from negative coordinates, which never lie in the window.
    send_beat(BEAT_ENDPOINT, -2, -1, 24'h000000, 8'd0);
    send_beat(BEAT_ENDPOINT, 1, 3, 24'h5A3C96, 8'd128);
    repeat (5) send_tick();
    // And back again, stepping down on both axes.
    send_beat(BEAT_ENDPOINT, -1, -1, 24'hA5C369, 8'd200);
    repeat (5) send_tick();

    // Random phases, each under its own clip window, written while the block is idle.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: set_window(0, CLIP_FAR_RESET, 0, CLIP_FAR_RESET);
        1: set_window(clamp_clip(plan_x - 16), clamp_clip(plan_x + 16),
                      clamp_clip(plan_y - 16), clamp_clip(plan_y + 16));
        // Inverted in x and empty in y: nothing can be inside.
        2: set_window(CLIP_FAR_RESET, 0, 0, 0);
        3: set_window($urandom_range(0, CLIP_FAR_RESET), $urandom_range(0, CLIP_FAR_RESET),
                      $urandom_range(0, CLIP_FAR_RESET), $urandom_range(0, CLIP_FAR_RESET));
        default: set_window(clamp_clip(plan_x - 4), clamp_clip(plan_x + 5),
                            clamp_clip(plan_y - 64), clamp_clip(plan_y + 64));
      endcase
      phase_start = beats_counted;
      while (beats_counted - phase_start < BEATS_PER_PHASE) begin
        // Partway into one phase, ask the result side for its long hold-off while
        // beats keep coming.
        if (phase == 1 && holds_done == 0 && !hold_request &&
            beats_counted - phase_start >= 20)
          hold_request = 1'b1;
        random_beat();
      end
    end

    settle();
    $display("Run drove %0d beats (%0d taking effect), %0d lines, under %0d clip windows.",
             beats_sent, beats_counted, lines_started, PHASES + 1);
    $display("Compared %0d pixels, %0d mismatches, %0d long result stall(s).",
             pixels_checked, failures, holds_done);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: a run that never drains ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d pixels outstanding.",
               cycle_count, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
